// ----- src/gww_pkg.sv -----
// Shared types and constants for the greedy word wrap block.
// Used by the controller, the datapath and the top level; no dependencies.
package gww_pkg;

  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 6;
  localparam int COL_W     = 6;
  localparam int SPACE_W   = 6;
  localparam int SUM_W     = 7;

  localparam logic [CHAR_W-1:0]  CH_SPACE      = 8'd32;
  localparam logic [CHAR_W-1:0]  CH_UNDERSCORE = 8'd95;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE    = 8'd10;
  localparam logic [SPACE_W-1:0] SPACE_MAX     = 6'd63;
  localparam logic [CFG_W-1:0]   WIDTH_CAP     = 6'd32;
  localparam logic [CFG_W-1:0]   CFG_RESET     = 6'd32;

  typedef enum logic [1:0] {
    SEL_NEWLINE,
    SEL_UNDERSCORE,
    SEL_WORD
  } sel_t;

  typedef struct packed {
    logic take;
    logic plan;
    logic emit;
    sel_t sel;
    logic last;
    logic word_adv;
    logic gap_dec;
    logic clr_word;
  } cmd_t;

  typedef struct packed {
    logic needs_flush;
    logic len_zero;
    logic wrap;
    logic pend_zero;
    logic gap_one;
    logic word_last;
    logic kind_eol;
    logic out_free;
  } stat_t;

endpackage

// ----- src/greedy_word_wrap.sv -----
// Greedy word wrap top level: ties the controller to the datapath.
// Depends on gww_pkg, gww_ctrl and gww_dp.
// Word bytes and spaces that end no word are single transfers that give no result.
// A word-ending space or an end of line is taken, then planned, then its results are
// loaded into the output one by one (held while stalled); no input is taken meanwhile.
// Synchronous reset clears word length, pending spaces and column and sets the width to 32, not the buffer.
module greedy_word_wrap
  import gww_pkg::*;
#(
  parameter int WORD_MAX = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,   // max_line_length
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] in_char
  input  logic [0:0]       s_axis_tuser,  // [0] end_of_line
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_char
  output logic [0:0]       m_axis_tuser,  // [0] word_overflow
  output logic             m_axis_tlast
);

  cmd_t  cmd;
  stat_t stat;

  assign s_axis_tready = cmd.take;

  gww_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .stat          (stat),
    .cmd           (cmd)
  );

  gww_dp #(
    .WORD_MAX (WORD_MAX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

// ----- src/gww_ctrl.sv -----
// Controller state machine of the greedy word wrap block.
// Depends on gww_pkg; drives the datapath through cmd_t and reads stat_t.
module gww_ctrl
  import gww_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_axis_tvalid,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_BREAK  = 6'b000100,
    ST_SPACES = 6'b001000,
    ST_WORD   = 6'b010000,
    ST_EOL    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.sel    = SEL_NEWLINE;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (s_axis_tvalid && stat.needs_flush) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.plan = 1'b1;
        if (stat.len_zero) begin
          state_next = ST_EOL;
        end else if (stat.wrap) begin
          state_next = ST_BREAK;
        end else if (!stat.pend_zero) begin
          state_next = ST_SPACES;
        end else begin
          state_next = ST_WORD;
        end
      end
      ST_BREAK: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_NEWLINE;
          state_next = ST_WORD;
        end
      end
      ST_SPACES: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_UNDERSCORE;
          cmd.gap_dec = 1'b1;
          if (stat.gap_one) begin
            state_next = ST_WORD;
          end
        end
      end
      ST_WORD: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_WORD;
          if (stat.word_last) begin
            cmd.last     = !stat.kind_eol;
            cmd.clr_word = 1'b1;
            state_next   = stat.kind_eol ? ST_EOL : ST_IDLE;
          end else begin
            cmd.word_adv = 1'b1;
          end
        end
      end
      ST_EOL: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_NEWLINE;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> stat.out_free)
    else $error("Result loaded while the output register is still full.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WORD || state == ST_BREAK || state == ST_SPACES) |-> !stat.len_zero)
    else $error("Word emission running with an empty word buffer.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |=> !cmd.take)
    else $error("Input taken right after the planning cycle.");

endmodule

// ----- src/gww_dp.sv -----
// Datapath of the greedy word wrap block: word buffer, counters, width
// register and output register. Depends on gww_pkg; controlled by gww_ctrl.
module gww_dp
  import gww_pkg::*;
#(
  parameter int WORD_MAX = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              s_axis_tvalid,
  input  logic [7:0]        s_axis_tdata,
  input  logic [0:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,
  output logic [0:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  input  cmd_t              cmd,
  output stat_t             stat
);

  localparam int LEN_W  = $clog2(WORD_MAX + 1);
  localparam int ADDR_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_MAX);

  logic [CHAR_W-1:0]  word_store [WORD_MAX];
  logic [CHAR_W-1:0]  rd_data;
  logic [ADDR_W-1:0]  rd_idx;
  logic [ADDR_W-1:0]  rd_idx_next;
  logic [LEN_W-1:0]   word_length;
  logic               word_dropped;
  logic [SPACE_W-1:0] pending_spaces;
  logic [SPACE_W-1:0] gap_cnt;
  logic [COL_W-1:0]   column;
  logic [CFG_W-1:0]   max_line_length;
  logic               kind_eol;
  logic               overflow;

  logic               acc;
  logic               in_eol;
  logic               in_space;
  logic [CFG_W-1:0]   width;
  logic [SUM_W-1:0]   sum;
  logic [CHAR_W-1:0]  emit_char;

  assign acc      = cmd.take && s_axis_tvalid;
  assign in_eol   = s_axis_tuser[0];
  assign in_space = (s_axis_tdata == CH_SPACE);
  assign width    = (max_line_length > WIDTH_CAP) ? WIDTH_CAP : max_line_length;
  assign sum      = SUM_W'(column) + SUM_W'(pending_spaces) + SUM_W'(word_length);

  assign stat.needs_flush = in_eol || (in_space && (word_length != '0));
  assign stat.len_zero    = (word_length == '0);
  assign stat.wrap        = (sum > SUM_W'(width));
  assign stat.pend_zero   = (pending_spaces == '0);
  assign stat.gap_one     = (gap_cnt == SPACE_W'(1));
  assign stat.word_last   = ((LEN_W'(rd_idx) + LEN_W'(1)) == word_length);
  assign stat.kind_eol    = kind_eol;
  assign stat.out_free    = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    if (cmd.plan) begin
      rd_idx_next = '0;
    end else if (cmd.word_adv) begin
      rd_idx_next = rd_idx + ADDR_W'(1);
    end else begin
      rd_idx_next = rd_idx;
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_UNDERSCORE: emit_char = CH_UNDERSCORE;
      SEL_WORD:       emit_char = rd_data;
      default:        emit_char = CH_NEWLINE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && !in_eol && !in_space && (word_length < LEN_MAX)) begin
      word_store[word_length[ADDR_W-1:0]] <= s_axis_tdata;
    end
    rd_data <= word_store[rd_idx_next];
    rd_idx  <= rd_idx_next;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      kind_eol <= in_eol;
    end
    if (cmd.plan) begin
      overflow <= (word_length != '0) && word_dropped;
      gap_cnt  <= pending_spaces;
    end else if (cmd.gap_dec) begin
      gap_cnt <= gap_cnt - SPACE_W'(1);
    end
    if (cmd.emit) begin
      m_axis_tdata    <= emit_char;
      m_axis_tuser[0] <= overflow;
      m_axis_tlast    <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length     <= '0;
      word_dropped    <= 1'b0;
      pending_spaces  <= '0;
      column          <= '0;
      max_line_length <= CFG_RESET;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_line_length <= cfg_wr_data;
      end
      if (acc && !in_eol) begin
        if (in_space) begin
          if ((word_length == '0) && (pending_spaces != SPACE_MAX)) begin
            pending_spaces <= pending_spaces + SPACE_W'(1);
          end
        end else if (word_length < LEN_MAX) begin
          word_length <= word_length + LEN_W'(1);
        end else begin
          word_dropped <= 1'b1;
        end
      end
      if (cmd.plan) begin
        pending_spaces <= kind_eol ? '0 : SPACE_W'(1);
        if (kind_eol) begin
          column <= '0;
        end else if (stat.wrap) begin
          column <= COL_W'(word_length);
        end else begin
          column <= sum[COL_W-1:0];
        end
      end
      if (cmd.clr_word) begin
        word_length  <= '0;
        word_dropped <= 1'b0;
      end
      if (cmd.emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) word_length <= LEN_MAX)
    else $error("Word length beyond the buffer depth.");

  assert property (@(posedge clk) disable iff (rst) column <= COL_W'(32))
    else $error("Column beyond the widest line.");

endmodule
